[hdl/bfe_pkg.sv]
// package for the bfs frontier edge expansion core
package bfe_pkg;
   localparam int NodeBits  = 10;
   localparam int BlockBits = 6;
   localparam int DistBits  = 32;
   localparam int CountBits = 11;
   localparam int NodeCount = 1 << NodeBits;

   typedef enum logic [1:0] {
      ACT_SEED    = 2'd0,
      ACT_MAP     = 2'd1,
      ACT_RELAX   = 2'd2,
      ACT_ADVANCE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_CLEAR
   } state_type;

   localparam logic CSR_GOAL  = 1'b0;
   localparam logic CSR_START = 1'b1;
endpackage

[hdl/bfs_frontier_edge_expand_core.sv]
// top level of the bfs frontier edge expansion core
// seed, map and relax results: the item is captured in ST_IDLE, executed in ST_EXEC and strobed from a register
// advance sweeps all 1024 node entries; the reset sweep clears all of them
// a relax that discovers the goal then walks the parent chain, reading and checking one hop at a time
// a new item is accepted only while idle, not during execute, sweeps or walks
// reset is synchronous; after reset the block is busy until the clearing sweep ends
module bfs_frontier_edge_expand_core
   import bfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  logic [NodeBits-1:0]  req_from_node,
   input  logic [NodeBits-1:0]  req_to_node,
   input  logic [15:0]          req_edge_weight,
   input  logic [BlockBits-1:0] req_block_in,
   input  logic                 req_block_none,
   output logic                 rsp_strobe,
   output logic                 rsp_discovered,
   output logic [NodeBits-1:0]  rsp_found_node,
   output logic [NodeBits-1:0]  rsp_found_parent,
   output logic [DistBits-1:0]  rsp_found_distance,
   output logic [NodeBits-1:0]  rsp_found_depth,
   output logic                 rsp_block_activated,
   output logic [BlockBits-1:0] rsp_activated_block,
   output logic                 rsp_goal_reached,
   output logic [CountBits-1:0] rsp_path_length,
   output logic [CountBits-1:0] rsp_visited_total,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   // node memories: flags {visited, cur, next, block valid}, block id, parent(+valid), dist, depth
   logic [3:0]           flag_mem  [NodeCount];
   logic [BlockBits-1:0] blk_mem   [NodeCount];
   logic [NodeBits:0]    par_mem   [NodeCount];
   logic [DistBits-1:0]  dist_mem  [NodeCount];
   logic [NodeBits-1:0]  dep_mem   [NodeCount];

   logic [NodeBits-1:0] goal_ff, start_ff;
   state_type state_ff, state_in;
   logic [NodeBits:0] sweep_ff, sweep_in;
   logic clear_all_ff, clear_all_in;
   logic [(1<<BlockBits)-1:0] sched_ff, sched_in;
   logic goal_flag_ff, goal_flag_in;
   logic [CountBits-1:0] count_ff, count_in, path_ff, path_in;
   logic [1:0] act_ff;
   logic [NodeBits-1:0] u_ff, v_ff, walk_ff, walk_in;
   logic [15:0] w_ff;
   logic [BlockBits-1:0] bin_ff;
   logic bnone_ff;

   // read data
   logic [3:0] fu_q, fv_q;
   logic [BlockBits-1:0] bv_q;
   logic [NodeBits:0] pw_q;
   logic [DistBits-1:0] du_q;
   logic [NodeBits-1:0] dpu_q;
   logic [NodeBits-1:0] ra_u, ra_v;

   // write controls
   logic fl_we; logic [NodeBits-1:0] fl_wa; logic [3:0] fl_wd;
   logic bk_we; logic [BlockBits-1:0] bk_wd;
   logic nd_we; logic [NodeBits-1:0] nd_wa; logic [NodeBits:0] pr_wd;
   logic [DistBits-1:0] ds_wd; logic [NodeBits-1:0] dp_wd;

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign pready = 1'b1;

   // config transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff <= '0; start_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == CSR_GOAL && paddr[1:0] == 2'b00) goal_ff <= pwdata[NodeBits-1:0];
         if (paddr[2] == CSR_START && paddr[1:0] == 2'b00) start_ff <= pwdata[NodeBits-1:0];
      end
   end
   assign prdata = (paddr[2] == CSR_START) ? {22'd0, start_ff} : {22'd0, goal_ff};

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action; u_ff <= req_from_node; v_ff <= req_to_node;
         w_ff <= req_edge_weight; bin_ff <= req_block_in; bnone_ff <= req_block_none;
      end
   end

   // read addresses
   always_comb begin
      ra_u = req_from_node;
      ra_v = req_to_node;
      if (state_ff == ST_CLEAR) ra_v = sweep_ff[NodeBits-1:0];
      else if (state_ff == ST_WALK_RD) ra_v = walk_ff;
   end

   always_ff @(posedge clock) begin
      fu_q  <= flag_mem[ra_u];
      du_q  <= dist_mem[ra_u];
      dpu_q <= dep_mem[ra_u];
      fv_q  <= flag_mem[ra_v];
      bv_q  <= blk_mem[ra_v];
      pw_q  <= par_mem[ra_v];
      if (fl_we) flag_mem[fl_wa] <= fl_wd;
      if (bk_we) blk_mem[fl_wa] <= bk_wd;
      if (nd_we) begin
         par_mem[nd_wa] <= pr_wd; dist_mem[nd_wa] <= ds_wd; dep_mem[nd_wa] <= dp_wd;
      end
   end

   // relax arithmetic
   logic relax_hit;
   logic [DistBits:0] dsum;
   logic [DistBits-1:0] nd;
   logic [NodeBits-1:0] ndp;
   always_comb begin
      relax_hit = fu_q[2] && !fv_q[3];
      dsum = {1'b0, du_q} + {{(DistBits-15){1'b0}}, w_ff};
      nd = dsum[DistBits] ? '1 : dsum[DistBits-1:0];
      ndp = (&dpu_q) ? dpu_q : dpu_q + 1'b1;
   end

   // control and writes
   logic out_fire, out_disc, out_bact;
   always_comb begin
      state_in = state_ff; sweep_in = sweep_ff; clear_all_in = clear_all_ff;
      sched_in = sched_ff; goal_flag_in = goal_flag_ff; count_in = count_ff;
      path_in = path_ff; walk_in = walk_ff;
      fl_we = 1'b0; fl_wa = u_ff; fl_wd = fu_q;
      bk_we = 1'b0; bk_wd = bin_ff;
      nd_we = 1'b0; nd_wa = u_ff; pr_wd = '0; ds_wd = '0; dp_wd = '0;
      out_fire = 1'b0; out_disc = 1'b0; out_bact = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (action_type'(act_ff))
               ACT_SEED: begin
                  fl_we = 1'b1; fl_wd = {1'b1, 1'b1, fu_q[1], fu_q[0]};
                  nd_we = 1'b1;
                  if (!fu_q[3] && !(&count_ff)) count_in = count_ff + 1'b1;
                  out_fire = 1'b1;
               end
               ACT_MAP: begin
                  fl_we = 1'b1; bk_we = 1'b1;
                  fl_wd = {fu_q[3:1], !bnone_ff};
                  out_fire = 1'b1;
               end
               ACT_RELAX: begin
                  if (relax_hit) begin
                     fl_we = 1'b1; fl_wa = v_ff;
                     fl_wd = {1'b1, fv_q[2], 1'b1, fv_q[0]};
                     nd_we = 1'b1; nd_wa = v_ff;
                     pr_wd = {1'b1, u_ff}; ds_wd = nd; dp_wd = ndp;
                     if (!(&count_ff)) count_in = count_ff + 1'b1;
                     out_disc = 1'b1;
                     if (fv_q[0] && !sched_ff[bv_q]) begin
                        sched_in[bv_q] = 1'b1; out_bact = 1'b1;
                     end
                     if (v_ff == goal_ff) begin
                        goal_flag_in = 1'b1; path_in = '0;
                        if (v_ff == start_ff) out_fire = 1'b1;
                        else begin
                           // goal's own parent is u
                           path_in = 11'd1; walk_in = u_ff;
                           if (u_ff == start_ff) out_fire = 1'b1;
                           else state_in = ST_WALK_RD;
                        end
                     end else out_fire = 1'b1;
                  end else out_fire = 1'b1;
               end
               ACT_ADVANCE: begin
                  sched_in = '0; clear_all_in = 1'b0;
                  sweep_in = '0; state_in = ST_CLEAR; out_fire = 1'b1;
               end
               default: ;
            endcase
         end
         ST_WALK_RD: state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            // pw_q is parent of walk node
            if (path_ff == CountBits'(NodeCount) || !pw_q[NodeBits]) begin
               state_in = ST_IDLE; out_fire = 1'b1;
               if (path_ff != CountBits'(NodeCount) && !pw_q[NodeBits])
                  path_in = path_ff + 1'b1;
            end else begin
               path_in = path_ff + 1'b1; walk_in = pw_q[NodeBits-1:0];
               if (pw_q[NodeBits-1:0] == start_ff || path_in == CountBits'(NodeCount)) begin
                  state_in = ST_IDLE; out_fire = 1'b1;
               end else state_in = ST_WALK_RD;
            end
         end
         ST_CLEAR: begin
            // sweep writes entry sweep-1 using read data from previous cycle
            if (sweep_ff != '0) begin
               fl_we = 1'b1; fl_wa = sweep_ff[NodeBits-1:0] - 1'b1;
               fl_wd = clear_all_ff ? 4'b0000 : {fv_q[3], fv_q[1], 1'b0, fv_q[0]};
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (NodeBits+1)'(NodeCount)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; sweep_ff <= '0; clear_all_ff <= 1'b1;
         sched_ff <= '0; goal_flag_ff <= 1'b0; count_ff <= '0; path_ff <= '0;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in; clear_all_ff <= clear_all_in;
         sched_ff <= sched_in; goal_flag_ff <= goal_flag_in; count_ff <= count_in;
         path_ff <= path_in;
      end
      walk_ff <= walk_in;
   end

   // result register
   logic disc_hold_ff, bact_hold_ff;
   logic [DistBits-1:0] nd_hold_ff;
   logic [NodeBits-1:0] ndp_hold_ff;
   logic [BlockBits-1:0] blk_hold_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         disc_hold_ff <= out_disc; bact_hold_ff <= out_bact;
         nd_hold_ff <= nd; ndp_hold_ff <= ndp; blk_hold_ff <= bv_q;
      end
   end
   logic strobe_ff;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= out_fire;
   end
   assign rsp_strobe = strobe_ff;
   assign rsp_discovered = disc_hold_ff;
   assign rsp_found_node = disc_hold_ff ? v_ff : '0;
   assign rsp_found_parent = disc_hold_ff ? u_ff : '0;
   assign rsp_found_distance = disc_hold_ff ? nd_hold_ff : '0;
   assign rsp_found_depth = disc_hold_ff ? ndp_hold_ff : '0;
   assign rsp_block_activated = bact_hold_ff;
   assign rsp_activated_block = bact_hold_ff ? blk_hold_ff : '0;
   assign rsp_goal_reached = goal_flag_ff;
   assign rsp_path_length = path_ff;
   assign rsp_visited_total = count_ff;
endmodule

[verif/testbench.sv]
// self-checking testbench for the bfs frontier edge expansion core
module testbench
   import bfe_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      action_type          action;
      logic [9:0]          from_node;
      logic [9:0]          to_node;
      logic [15:0]         edge_weight;
      logic [5:0]          block_in;
      logic                block_none;
   } bfs_cmd_type;

   typedef struct {
      logic                discovered;
      logic [9:0]          found_node;
      logic [9:0]          found_parent;
      logic [31:0]         found_distance;
      logic [9:0]          found_depth;
      logic                block_activated;
      logic [5:0]          activated_block;
      logic                goal_reached;
      logic [10:0]         path_length;
      logic [10:0]         visited_total;
   } expansion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_action = ACT_SEED;
   logic [9:0]  req_from_node = '0;
   logic [9:0]  req_to_node = '0;
   logic [15:0] req_edge_weight = '0;
   logic [5:0]  req_block_in = '0;
   logic        req_block_none = 1'b0;
   logic        rsp_strobe, rsp_discovered, rsp_block_activated, rsp_goal_reached;
   logic [9:0]  rsp_found_node, rsp_found_parent, rsp_found_depth;
   logic [31:0] rsp_found_distance;
   logic [5:0]  rsp_activated_block;
   logic [10:0] rsp_path_length, rsp_visited_total;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bfs_frontier_edge_expand_core dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_from_node, .req_to_node, .req_edge_weight,
      .req_block_in, .req_block_none,
      .rsp_strobe, .rsp_discovered, .rsp_found_node, .rsp_found_parent,
      .rsp_found_distance, .rsp_found_depth, .rsp_block_activated,
      .rsp_activated_block, .rsp_goal_reached, .rsp_path_length,
      .rsp_visited_total,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #6 clock = ~clock;

   // predictor state
   logic [9:0]  goal_reg = '0;
   logic [9:0]  root_reg = '0;
   bit          seen_mark [NodeCount];
   bit          cur_mark [NodeCount];
   bit          nxt_mark [NodeCount];
   bit          has_parent [NodeCount];
   logic [9:0]  parent_of [NodeCount];
   logic [31:0] dist_of [NodeCount];
   logic [9:0]  depth_of [NodeCount];
   bit          has_block [NodeCount];
   logic [5:0]  block_of [NodeCount];
   bit          block_hit [64];
   bit          goal_seen = 0;
   logic [10:0] visits = '0;
   logic [10:0] chain_len = '0;

   bfs_cmd_type   cmd_queue [$];
   expansion_type expected_q [$];
   int          idle_pct = 9;
   bit          hold_cmds = 0;
   int          errors = 0;
   int          n_accepted = 0;
   int          n_checked = 0;
   int          n_found = 0;
   int          n_goal = 0;
   int          n_advance = 0;

   // stimulus-side view of the frontier, only used to bias choices
   bit          g_seen [NodeCount];
   bit          g_cur [NodeCount];
   bit          g_nxt [NodeCount];
   int          g_front [$];
   int          g_front_next [$];

   function automatic logic [10:0] chain_hops(logic [9:0] node);
      logic [10:0] hops;
      logic [9:0]  at;
      hops = 0;
      at = node;
      while (hops < NodeCount && at != root_reg) begin
         hops++;
         if (!has_parent[at]) break;
         at = parent_of[at];
      end
      return hops;
   endfunction

   // compute the expansion result of one accepted command
   function automatic void expand_cmd(bfs_cmd_type c);
      expansion_type e;
      logic [32:0] sum;
      logic [9:0]  u, v;
      e = '{default: '0};
      u = c.from_node;
      v = c.to_node;
      case (c.action)
         ACT_SEED: begin
            if (!seen_mark[u] && visits != 11'h7ff) visits++;
            seen_mark[u] = 1;
            cur_mark[u] = 1;
            has_parent[u] = 0;
            parent_of[u] = '0;
            dist_of[u] = '0;
            depth_of[u] = '0;
         end
         ACT_MAP: begin
            has_block[u] = !c.block_none;
            block_of[u] = c.block_none ? 6'd0 : c.block_in;
         end
         ACT_RELAX: begin
            if (cur_mark[u] && !seen_mark[v]) begin
               sum = {1'b0, dist_of[u]} + {17'd0, c.edge_weight};
               seen_mark[v] = 1;
               nxt_mark[v] = 1;
               has_parent[v] = 1;
               parent_of[v] = u;
               dist_of[v] = sum[32] ? 32'hffff_ffff : sum[31:0];
               depth_of[v] = (depth_of[u] == 10'h3ff) ? 10'h3ff : depth_of[u] + 10'd1;
               if (visits != 11'h7ff) visits++;
               e.discovered = 1;
               e.found_node = v;
               e.found_parent = u;
               e.found_distance = dist_of[v];
               e.found_depth = depth_of[v];
               if (has_block[v] && !block_hit[block_of[v]]) begin
                  block_hit[block_of[v]] = 1;
                  e.block_activated = 1;
                  e.activated_block = block_of[v];
               end
               if (v == goal_reg) begin
                  goal_seen = 1;
                  chain_len = chain_hops(v);
                  n_goal++;
               end
               n_found++;
            end
         end
         default: begin
            cur_mark = nxt_mark;
            foreach (nxt_mark[i]) nxt_mark[i] = 0;
            foreach (block_hit[i]) block_hit[i] = 0;
            n_advance++;
         end
      endcase
      e.goal_reached = goal_seen;
      e.path_length = chain_len;
      e.visited_total = visits;
      expected_q.insert(expected_q.size(), e);
   endfunction

   // driver: presents queued commands on the start/busy handshake
   bfs_cmd_type cur_cmd;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expand_cmd(cur_cmd);
            n_accepted++;
         end
         if (!start || !busy) begin
            if (!hold_cmds && cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               cur_cmd = cmd_queue.pop_front();
               start <= 1'b1;
               req_action <= cur_cmd.action;
               req_from_node <= cur_cmd.from_node;
               req_to_node <= cur_cmd.to_node;
               req_edge_weight <= cur_cmd.edge_weight;
               req_block_in <= cur_cmd.block_in;
               req_block_none <= cur_cmd.block_none;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // monitor: every strobed result transfer against the oldest expectation
   always @(posedge clock) begin
      expansion_type e;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual node %0h",
                     $time, rsp_found_node);
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("discovered", 32'(e.discovered), 32'(rsp_discovered));
            check_field("found_node", 32'(e.found_node), 32'(rsp_found_node));
            check_field("found_parent", 32'(e.found_parent), 32'(rsp_found_parent));
            check_field("found_distance", e.found_distance, rsp_found_distance);
            check_field("found_depth", 32'(e.found_depth), 32'(rsp_found_depth));
            check_field("block_activated", 32'(e.block_activated),
                        32'(rsp_block_activated));
            check_field("activated_block", 32'(e.activated_block),
                        32'(rsp_activated_block));
            check_field("goal_reached", 32'(e.goal_reached), 32'(rsp_goal_reached));
            check_field("path_length", 32'(e.path_length), 32'(rsp_path_length));
            check_field("visited_total", 32'(e.visited_total), 32'(rsp_visited_total));
            n_checked++;
         end
      end
   end

   function automatic void add_cmd(action_type a, int u, int v, int w, int b, bit n);
      bfs_cmd_type c;
      c.action = a;
      c.from_node = 10'(u);
      c.to_node = 10'(v);
      c.edge_weight = 16'(w);
      c.block_in = 6'(b);
      c.block_none = n;
      cmd_queue.insert(cmd_queue.size(), c);
      // track the frontier for biasing later choices
      case (a)
         ACT_SEED: begin
            g_seen[u] = 1;
            if (!g_cur[u]) g_front.insert(g_front.size(), u);
            g_cur[u] = 1;
         end
         ACT_RELAX: begin
            if (g_cur[u] && !g_seen[v]) begin
               g_seen[v] = 1;
               g_nxt[v] = 1;
               g_front_next.insert(g_front_next.size(), v);
            end
         end
         ACT_ADVANCE: begin
            g_cur = g_nxt;
            foreach (g_nxt[i]) g_nxt[i] = 0;
            g_front = g_front_next;
            g_front_next.delete();
         end
         default: ;
      endcase
   endfunction

   function automatic int fresh_node();
      int n;
      n = $urandom_range(NodeCount - 1);
      for (int k = 0; k < 8 && g_seen[n]; k++) n = $urandom_range(NodeCount - 1);
      return n;
   endfunction

   function automatic void random_cmd();
      int r, u, v;
      r = $urandom_range(99);
      if (r < 6) begin
         add_cmd(ACT_SEED, ($urandom_range(3) == 0) ? root_reg : $urandom_range(1023),
                 $urandom, $urandom, $urandom, $urandom);
      end else if (r < 14) begin
         add_cmd(ACT_MAP, $urandom_range(1023), $urandom, $urandom, $urandom_range(63),
                 $urandom_range(3) == 0);
      end else if (r < 22) begin
         add_cmd(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         if (g_front.size() > 0 && $urandom_range(99) < 85)
            u = g_front[$urandom_range(g_front.size() - 1)];
         else
            u = $urandom_range(1023);
         if ($urandom_range(99) < 6) v = goal_reg;
         else if ($urandom_range(99) < 80) v = fresh_node();
         else v = $urandom_range(1023);
         add_cmd(ACT_RELAX, u, v, $urandom_range(65535), $urandom, $urandom);
      end
   endfunction

   task automatic wait_quiet();
      while (cmd_queue.size() > 0 || start || expected_q.size() > 0 || busy)
         @(posedge clock);
   endtask

   // register write, setup then access, then a read back
   task automatic csr_write(logic csr_idx, logic [9:0] value);
      wait_quiet();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {csr_idx, 2'b00};
      pwdata <= {22'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (!pready || prdata !== {22'd0, value}) begin
         $display("%0t: register read mismatch, expected %0h, actual %0h",
                  $time, value, prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      if (csr_idx == CSR_GOAL) goal_reg = value;
      else root_reg = value;
   endtask

   initial begin
      int f;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(CSR_GOAL, 10'd7);
      csr_write(CSR_START, 10'd1);

      // directed opening: maps, seeds, edge cases of relax, level advance
      add_cmd(ACT_MAP, 7, 0, 0, 63, 0);
      add_cmd(ACT_MAP, 1023, 0, 0, 0, 0);
      add_cmd(ACT_MAP, 2, 0, 0, 63, 0);
      add_cmd(ACT_MAP, 3, 0, 0, 21, 1);
      add_cmd(ACT_SEED, 1, 0, 0, 0, 0);
      add_cmd(ACT_SEED, 1, 0, 0, 0, 0);
      add_cmd(ACT_RELAX, 1, 1023, 16'hffff, 0, 0);
      add_cmd(ACT_RELAX, 1, 2, 0, 0, 0);
      add_cmd(ACT_RELAX, 1, 3, 1, 0, 0);
      add_cmd(ACT_RELAX, 1, 2, 5, 0, 0);
      add_cmd(ACT_RELAX, 1023, 0, 9, 0, 0);
      add_cmd(ACT_RELAX, 0, 1, 9, 0, 0);
      add_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0);
      add_cmd(ACT_RELAX, 1023, 0, 16'hffff, 0, 0);
      add_cmd(ACT_RELAX, 2, 7, 16'h8000, 0, 0);
      add_cmd(ACT_RELAX, 3, 9, 16'hffff, 0, 0);
      add_cmd(ACT_SEED, 1023, 0, 0, 0, 0);
      add_cmd(ACT_RELAX, 1023, 5, 3, 0, 0);
      add_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0);
      add_cmd(ACT_RELAX, 7, 8, 2, 0, 0);

      // random phases with different register settings and idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         if (ph > 0) begin
            csr_write(CSR_GOAL, (ph == 1) ? 10'd1023 : 10'd0);
            csr_write(CSR_START, (ph == 1) ? 10'd0 : 10'd1023);
            if (ph == 2) csr_write(CSR_GOAL, 10'(fresh_node()));
         end
         idle_pct = (ph == 0) ? 9 : (ph == 1) ? 64 : 0;
         if (ph > 0) add_cmd(ACT_SEED, root_reg, 0, 0, 0, 0);
         for (f = 0; f < 283; f++) begin
            random_cmd();
            // pause the sender once until all results are in
            if (ph == 1 && f == 140) begin
               while (cmd_queue.size() > 0 || start) @(posedge clock);
               hold_cmds = 1;
               while (expected_q.size() > 0) @(posedge clock);
               hold_cmds = 0;
            end
         end
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      $display("covered %0d commands, %0d results checked, %0d discoveries,",
               n_accepted, n_checked, n_found);
      $display("%0d goal hits and %0d level advances", n_goal, n_advance);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout at %0t", $time);
      $display("testbench: errors");
      $finish;
   end
endmodule

[files.f]
hdl/bfe_pkg.sv
hdl/bfs_frontier_edge_expand_core.sv
verif/testbench.sv
